FILE: rtl/brm_pkg.sv
// Package with the shared constants, types and conversions of the Booth multiplier.
`default_nettype none

package brm_pkg;

  localparam int FieldW = 32;
  localparam int OpW = 32;
  localparam int CntW = $clog2(OpW + 2);

  typedef enum logic [1:0] {
    BoothNone = 2'b00,
    BoothAdd  = 2'b01,
    BoothSub  = 2'b10,
    BoothKeep = 2'b11
  } booth_e;

  typedef struct packed {
    logic [OpW-1:0] acc;
    logic [OpW-1:0] q;
    logic           prev;
    logic [OpW-1:0] md;
  } stage_t;

  function automatic logic [OpW-1:0] to_operand(logic [FieldW-1:0] v);
    return OpW'(signed'(v));
  endfunction

  function automatic logic [FieldW-1:0] to_field(logic [OpW-1:0] v);
    return FieldW'(signed'(v));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/brm_if.sv
// Interfaces for the operand request channel and the product channel.
`default_nettype none

interface brm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] multiplicand;
  logic signed [31:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface brm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] product_low;

  modport source (output valid, output product_low, input ready);
  modport sink (input valid, input product_low, output ready);
endinterface

`default_nettype wire

FILE: rtl/brm_cell.sv
// One Booth step cell: recodes a bit pair, adds or subtracts, and shifts right.
`default_nettype none

module brm_cell
  import brm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire stage_t data_i,
  output      logic   ready_o,
  output      logic   valid_o,
  output      stage_t data_o,
  input  wire logic   ready_i
);

  logic           valid_q;
  stage_t         data_q;
  stage_t         data_d;
  logic [OpW-1:0] sum;

  always_comb begin
    case (booth_e'({data_i.q[0], data_i.prev}))
      BoothSub: sum = data_i.acc - data_i.md;
      BoothAdd: sum = data_i.acc + data_i.md;
      default:  sum = data_i.acc;
    endcase
    data_d.acc  = {sum[OpW-1], sum[OpW-1:1]};
    data_d.q    = {sum[0], data_i.q[OpW-1:1]};
    data_d.prev = data_i.q[0];
    data_d.md   = data_i.md;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/booth_radix2_multiplier_unit.sv
// Top level of the pipelined radix-2 Booth signed multiplier.
//
// The in_i channel carries a request with a signed multiplicand and multiplier;
// the out_o channel returns the low 32 bits of their product, wrapping on overflow.
// Both channels move an item when valid and ready are high at a rising clock edge.
// The datapath is a row of 32 identical Booth cells, one per multiplier bit,
// and each cell holds one request and its partial product in registers.
// A request accepted by the first cell moves through the registers of the cells in order,
// and its product is shown on out_o from the register of the last cell.
// Without a stall on out_o, the throughput is one request per cycle.
// The last cell is the output register. When the receiver stalls, the product
// is held there, and each cell that is empty keeps taking data from its left
// neighbor, so requests are still accepted until every cell is full.
// Reset clears the valid flag of every cell; the pipeline is then empty and
// ready to accept a request at the first edge after reset is released.
`default_nettype none

module booth_radix2_multiplier_unit
  import brm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brm_in_if.sink    in_i,
  brm_out_if.source out_o
);

  logic   valid [OpW+1];
  logic   ready [OpW+1];
  stage_t data  [OpW+1];
  logic [OpW-1:0] cell_valid;
  logic [CntW-1:0] fill;

  always_comb begin
    data[0].acc  = '0;
    data[0].q    = to_operand(in_i.multiplier);
    data[0].prev = 1'b0;
    data[0].md   = to_operand(in_i.multiplicand);
  end

  assign valid[0]   = in_i.valid;
  assign in_i.ready = ready[0];

  for (genvar i = 0; i < OpW; i++) begin : g_cell
    brm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .data_i  (data[i]),
      .ready_o (ready[i]),
      .valid_o (valid[i+1]),
      .data_o  (data[i+1]),
      .ready_i (ready[i+1])
    );
    assign cell_valid[i] = valid[i+1];
  end

  assign ready[OpW]        = out_o.ready;
  assign out_o.valid       = valid[OpW];
  assign out_o.product_low = to_field(data[OpW].q);

  assign fill = CntW'($countones(cell_valid));

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&cell_valid && !out_o.ready) |-> !in_i.ready)
    else $error("request accepted while every cell is full and the output stalls");

  a_fill_tracks_traffic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (int'(fill) == int'($past(fill))
      + int'($past(in_i.valid && in_i.ready))
      - int'($past(out_o.valid && out_o.ready))))
    else $error("pipeline occupancy does not match accepted and delivered requests");

  a_empty_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid == '0) |-> !out_o.valid)
    else $error("product shown with no request in the pipeline");

endmodule

`default_nettype wire

FILE: test/booth_product_checker.sv
// Checker that watches the operand and product channels and compares every product.
module booth_product_checker
  import brm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brm_in_if         req_i,
  brm_out_if        prod_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [FieldW-1:0] product_queue[$];
  logic [FieldW-1:0] want_product;

  function automatic logic [FieldW-1:0] booth_low_product(logic [FieldW-1:0] mcand,
                                                          logic [FieldW-1:0] mplier);
    logic [OpW-1:0] md;
    logic [OpW-1:0] acc;
    logic [OpW-1:0] q;
    logic           prev;
    md   = OpW'($signed(mcand));
    q    = OpW'($signed(mplier));
    acc  = '0;
    prev = 1'b0;
    for (int step = 0; step < OpW; step++) begin
      case (booth_e'({q[0], prev}))
        BoothSub: acc = acc - md;
        BoothAdd: acc = acc + md;
        default: ;
      endcase
      prev = q[0];
      q    = {acc[0], q[OpW-1:1]};
      acc  = {acc[OpW-1], acc[OpW-1:1]};
    end
    return FieldW'($signed(q));
  endfunction

  task automatic report_mismatch(string what, logic [FieldW-1:0] want, logic [FieldW-1:0] got);
    $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (prod_i.valid && prod_i.ready) begin
        if (product_queue.size() == 0) begin
          report_mismatch("product with no request outstanding", '0, prod_i.product_low);
        end else begin
          want_product = product_queue.pop_front();
          if (prod_i.product_low !== want_product) begin
            report_mismatch("product_low", want_product, prod_i.product_low);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        product_queue.push_back(booth_low_product(req_i.multiplicand, req_i.multiplier));
      end
      pending_o = product_queue.size();
    end
  end

endmodule

FILE: test/booth_radix2_multiplier_unit_test.sv
// Top of the testbench: clock, reset, operand stimulus, product stalls and the verdict.
module booth_radix2_multiplier_unit_test;
  import brm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 1300;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  bit   steady_run;

  brm_in_if  op_bus ();
  brm_out_if prod_bus ();

  booth_radix2_multiplier_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_bus),
    .out_o (prod_bus)
  );

  booth_product_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (op_bus),
    .prod_i      (prod_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    if (steady_run || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'($signed($urandom_range(0, 32)) - 16);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          3: v = 32'h0000_0001;
          default: v = 32'h0000_0000;
        endcase
      end
      2: begin
        v = 32'h1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
          v = ~v;
        end
      end
      3: v = $signed($urandom()) >>> $urandom_range(1, 31);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_request(logic [31:0] mcand, logic [31:0] mplier);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      op_bus.valid        <= 1'b0;
      op_bus.multiplicand <= $urandom();
      op_bus.multiplier   <= $urandom();
      repeat (gap) @(negedge clk_i);
    end
    op_bus.valid        <= 1'b1;
    op_bus.multiplicand <= mcand;
    op_bus.multiplier   <= mplier;
    do @(posedge clk_i); while (!op_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_products();
    op_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int gap;
    prod_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        prod_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      prod_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!prod_bus.valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cycle_count         = 0;
    steady_run          = 1'b0;
    rst_ni              = 1'b0;
    op_bus.valid        = 1'b0;
    op_bus.multiplicand = '0;
    op_bus.multiplier   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0001, 32'h0000_0001);
    send_request(32'hffff_ffff, 32'hffff_ffff);
    send_request(32'hffff_ffff, 32'h8000_0000);
    send_request(32'h8000_0000, 32'hffff_ffff);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'h7fff_ffff, 32'h7fff_ffff);
    send_request(32'h8000_0000, 32'h7fff_ffff);
    send_request(32'h7fff_ffff, 32'hffff_ffff);
    send_request(32'h0000_0000, 32'h8000_0000);
    send_request(32'h8000_0000, 32'h0000_0000);
    send_request(32'h0000_0001, 32'hffff_ffff);
    send_request(32'h5555_5555, 32'haaaa_aaaa);
    send_request(32'haaaa_aaaa, 32'h5555_5555);
    send_request(32'h0000_ffff, 32'h0000_ffff);
    send_request(32'h0001_0000, 32'h0001_0000);
    send_request(32'h0000_3039, 32'hffff_e57b);
    send_request(32'hffff_fffe, 32'h4000_0000);
    send_request(32'h7fff_ffff, 32'h0000_0002);
    send_request(32'h1234_5678, 32'h8765_4321);
    drain_products();

    for (int idx = 0; idx < RandomItems; idx++) begin
      if (idx % 100 == 0) begin
        steady_run = (idx % 400 == 100);
      end
      if (idx % 400 == 399) begin
        drain_products();
      end
      send_request(pick_operand(), pick_operand());
    end
    steady_run = 1'b0;
    drain_products();
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
